// ===== src/bfu_pkg.sv =====
// shared constants, types and blend functions of the bilinear frame upscaler
package bfu_pkg;

    localparam int SRC_WIDTH_DEF     = 480;
    localparam int SRC_HEIGHT_DEF    = 360;
    localparam int MAX_OUT_WIDTH_DEF = 4096;
    localparam int FIFO_DEPTH        = 4;

    localparam logic [14:0] OUT_WIDTH_RESET  = 15'd480;
    localparam logic [14:0] OUT_HEIGHT_RESET = 15'd360;

    localparam logic [1:0] CFG_OUT_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_OUT_HEIGHT = 2'd1;

    localparam logic       CMD_WRITE  = 1'b0;
    localparam logic       CMD_RENDER = 1'b1;
    localparam logic [7:0] ALPHA      = 8'hFF;
    localparam logic [7:0] FRAC_EDGE  = 8'hFF;

    typedef struct packed {
        logic        is_render;
        logic        wen;
        logic [23:0] rgb;
        logic [7:0]  frac_x;
        logic [7:0]  frac_y;
    } t_op;

    function automatic logic [7:0] blend8(logic [7:0] p, logic [7:0] q, logic [7:0] f);
        logic [8:0]  g;
        logic [16:0] s;
        g = 9'd256 - {1'b0, f};
        s = 17'(p) * 17'(g) + 17'(q) * 17'({1'b0, f});
        return s[15:8];
    endfunction

    function automatic logic [23:0] blend24(logic [23:0] p, logic [23:0] q, logic [7:0] f);
        return {blend8(p[23:16], q[23:16], f), blend8(p[15:8], q[15:8], f),
                blend8(p[7:0], q[7:0], f)};
    endfunction

endpackage

// ===== src/bfu_ram.sv =====
// generic single-write dual-read ram with registered read data
module bfu_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [W-1:0]             o_rdata_a,
    output logic [W-1:0]             o_rdata_b
);
    logic [W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule

// ===== src/bfu_fifo.sv =====
// short register queue between the front and back parts
module bfu_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== src/bfu_locate.sv =====
// pipelined restoring divider mapping an output coordinate to source index and weight
module bfu_locate #(
    parameter int SRC = 480,
    parameter int CW  = 14,
    parameter int QB  = 17
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [CW-1:0]          i_coord,
    input  logic [14:0]            i_div,
    output logic [$clog2(SRC)-1:0] o_idx,
    output logic [7:0]             o_frac
);
    localparam int RW = CW + QB + 16;
    localparam int IW = $clog2(SRC);
    localparam logic [RW-1:0] SRC_C = RW'(SRC);
    localparam logic [QB-1:0] SAT_Q = QB'((SRC - 1) * 256);

    logic [RW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_ovf [0:QB];
    logic          sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (RW'(i_coord) * SRC_C) << 8;
            r_q[0]   <= '0;
            r_ovf[0] <= 1'b0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= QB; j++) begin : g_stage
        logic [RW-1:0] dk;
        logic          ge;
        logic          ovf;
        assign dk  = RW'(i_div) << (QB - j);
        assign ge  = (r_rem[j-1] >= dk);
        assign ovf = (j == 1) ? (r_rem[j-1] >= (RW'(i_div) << QB)) : 1'b0;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? r_rem[j-1] - dk : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (QB'(ge) << (QB - j));
                r_ovf[j] <= r_ovf[j-1] | ovf;
            end
        end
    end

    assign sat    = r_ovf[QB] || (r_q[QB] >= SAT_Q);
    assign o_idx  = sat ? IW'(SRC - 2) : r_q[QB][8 +: IW];
    assign o_frac = sat ? bfu_pkg::FRAC_EDGE : r_q[QB][7:0];
endmodule

// ===== src/bfu_front.sv =====
// front part: accepts beats, computes addresses and weights
module bfu_front #(
    parameter int SRC_W  = 480,
    parameter int SRC_H  = 360,
    parameter int MAX_OW = 4096,
    parameter int QB     = 17,
    parameter int AW     = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_cmd,
    input  logic [8:0]     i_src_x,
    input  logic [8:0]     i_src_y,
    input  logic [23:0]    i_src_rgb,
    input  logic [13:0]    i_out_x,
    input  logic [13:0]    i_out_y,
    input  logic [14:0]    i_div_x,
    input  logic [14:0]    i_div_y,
    output logic           o_valid,
    input  logic           i_full,
    output bfu_pkg::t_op   o_op,
    output logic [AW-1:0]  o_addr
);
    localparam int IWX = $clog2(SRC_W);
    localparam int IWY = $clog2(SRC_H);

    logic           r_v    [0:QB];
    bfu_pkg::t_op   r_op   [0:QB];
    logic [AW-1:0]  r_addr [0:QB];
    logic           en;
    logic [13:0]    ox;
    logic [IWX-1:0] x0;
    logic [IWY-1:0] y0;
    logic [7:0]     fx, fy;

    assign en      = !(r_v[QB] && i_full);
    assign o_ready = en;
    assign ox      = ({1'b0, i_out_x} > 15'(MAX_OW - 1)) ? 14'(MAX_OW - 1) : i_out_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QB; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j <= QB; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op[0].is_render <= (i_cmd == bfu_pkg::CMD_RENDER);
            r_op[0].wen       <= (32'(i_src_x) < SRC_W) && (32'(i_src_y) < SRC_H);
            r_op[0].rgb       <= i_src_rgb;
            r_op[0].frac_x    <= '0;
            r_op[0].frac_y    <= '0;
            r_addr[0]         <= AW'(i_src_y) * AW'(SRC_W) + AW'(i_src_x);
            for (int j = 1; j <= QB; j++) begin
                r_op[j]   <= r_op[j-1];
                r_addr[j] <= r_addr[j-1];
            end
        end
    end

    bfu_locate #(.SRC(SRC_W), .CW(14), .QB(QB)) u_loc_x (
        .i_clk(i_clk), .i_en(en), .i_coord(ox), .i_div(i_div_x), .o_idx(x0), .o_frac(fx)
    );
    bfu_locate #(.SRC(SRC_H), .CW(14), .QB(QB)) u_loc_y (
        .i_clk(i_clk), .i_en(en), .i_coord(i_out_y), .i_div(i_div_y), .o_idx(y0), .o_frac(fy)
    );

    always_comb begin
        o_op        = r_op[QB];
        o_op.frac_x = fx;
        o_op.frac_y = fy;
        o_addr      = r_op[QB].is_render ? AW'(y0) * AW'(SRC_W) + AW'(x0) : r_addr[QB];
    end

    assign o_valid = r_v[QB];
endmodule

// ===== src/bfu_back.sv =====
// back part: frame store access, two-step blend and output register
module bfu_back #(
    parameter int SRC_W = 480,
    parameter int DEPTH = 172800,
    parameter int AW    = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_pop,
    input  bfu_pkg::t_op  i_op,
    input  logic [AW-1:0] i_addr,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [31:0]   o_tdata
);
    logic        adv, fire, we;
    logic        r_v1, r_v2, r_v3;
    logic [7:0]  r_fx1, r_fy1, r_fy2;
    logic [23:0] p00, p01, p10, p11;
    logic [23:0] r_top, r_bot;
    logic [31:0] r_pix;

    assign adv   = !r_v3 || i_tready;
    assign fire  = adv && i_valid;
    assign o_pop = fire;
    assign we    = fire && !i_op.is_render && i_op.wen;

    // two copies so all four neighbours are read out in the same cycle
    bfu_ram #(.W(24), .DEPTH(DEPTH)) u_ram_row0 (
        .i_clk(i_clk), .i_we(we), .i_waddr(i_addr), .i_wdata(i_op.rgb), .i_re(adv),
        .i_raddr_a(i_addr), .i_raddr_b(i_addr + 1'b1),
        .o_rdata_a(p00), .o_rdata_b(p01)
    );
    bfu_ram #(.W(24), .DEPTH(DEPTH)) u_ram_row1 (
        .i_clk(i_clk), .i_we(we), .i_waddr(i_addr), .i_wdata(i_op.rgb), .i_re(adv),
        .i_raddr_a(i_addr + AW'(SRC_W)), .i_raddr_b(i_addr + AW'(SRC_W + 1)),
        .o_rdata_a(p10), .o_rdata_b(p11)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= fire && i_op.is_render;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fx1 <= i_op.frac_x;
            r_fy1 <= i_op.frac_y;
            r_top <= bfu_pkg::blend24(p00, p01, r_fx1);
            r_bot <= bfu_pkg::blend24(p10, p11, r_fx1);
            r_fy2 <= r_fy1;
            r_pix <= {bfu_pkg::ALPHA, bfu_pkg::blend24(r_top, r_bot, r_fy2)};
        end
    end

    assign o_tvalid = r_v3;
    assign o_tdata  = r_pix;
endmodule

// ===== src/bilinear_frame_upscaler_top.sv =====
// top level of the bilinear frame upscaler
//
//  channel   direction  beat                  contents
//  s_axis    in         write or render item  tdata/tuser below
//  m_axis    out        one rendered pixel    tdata = pixel
//  cfg       in         register write        index 0 out_width, 1 out_height
//
// one item per cycle sustained unless a full queue or m_axis tready holds it back; a render
// beat passes a load stage and QB divider stages (one quotient bit each), the queue, then
// three back stages (ram read, x blend, y blend)
// writes go down the same path and reach the frame store in order with renders
// reset clears control only; the frame store holds garbage until written
// front and back stall independently through the four-entry queue
module bilinear_frame_upscaler_top #(
    parameter int SRC_WIDTH     = bfu_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT    = bfu_pkg::SRC_HEIGHT_DEF,
    parameter int MAX_OUT_WIDTH = bfu_pkg::MAX_OUT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // src_x[8:0], src_y[17:9], src_rgb[41:18], out_x[55:42], out_y[69:56], zero pad
    input  logic [71:0] i_s_axis_tdata,
    // cmd[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel[31:0]
    output logic [31:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    localparam int SBX   = $clog2(SRC_WIDTH + 1);
    localparam int SBY   = $clog2(SRC_HEIGHT + 1);
    localparam int QB    = ((SBX > SBY) ? SBX : SBY) + 8;
    localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $bits(bfu_pkg::t_op) + AW;

    logic [14:0]   r_out_w, r_out_h;
    logic [14:0]   div_x, div_y;
    logic          f_valid, q_full, q_valid, q_pop;
    bfu_pkg::t_op  f_op, b_op;
    logic [AW-1:0] f_addr, b_addr;
    logic [EW-1:0] q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_w <= bfu_pkg::OUT_WIDTH_RESET;
            r_out_h <= bfu_pkg::OUT_HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bfu_pkg::CFG_OUT_WIDTH) begin
                r_out_w <= i_cfg_data;
            end else if (i_cfg_index == bfu_pkg::CFG_OUT_HEIGHT) begin
                r_out_h <= i_cfg_data;
            end
        end
    end

    // a zero size divides as one
    assign div_x = (r_out_w == '0) ? 15'd1 : r_out_w;
    assign div_y = (r_out_h == '0) ? 15'd1 : r_out_h;

    bfu_front #(
        .SRC_W(SRC_WIDTH), .SRC_H(SRC_HEIGHT), .MAX_OW(MAX_OUT_WIDTH), .QB(QB), .AW(AW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid), .o_ready(o_s_axis_tready),
        .i_cmd(i_s_axis_tuser),
        .i_src_x(i_s_axis_tdata[8:0]), .i_src_y(i_s_axis_tdata[17:9]),
        .i_src_rgb(i_s_axis_tdata[41:18]),
        .i_out_x(i_s_axis_tdata[55:42]), .i_out_y(i_s_axis_tdata[69:56]),
        .i_div_x(div_x), .i_div_y(div_y),
        .o_valid(f_valid), .i_full(q_full), .o_op(f_op), .o_addr(f_addr)
    );

    bfu_fifo #(.W(EW), .DEPTH(bfu_pkg::FIFO_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_valid && !q_full), .i_data({f_op, f_addr}), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_out)
    );

    assign {b_op, b_addr} = q_out;

    bfu_back #(.SRC_W(SRC_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_pop(q_pop), .i_op(b_op), .i_addr(b_addr),
        .o_tvalid(o_m_axis_tvalid), .i_tready(i_m_axis_tready), .o_tdata(o_m_axis_tdata)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("queue popped while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid) else $error("result beat right after reset");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[31:24] == bfu_pkg::ALPHA))
        else $error("alpha not opaque");

    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (f_valid && q_full)) else $error("front stalled without cause");
endmodule
